/* rtl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared action codes, reduction source selects and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

	// Default operand width in bits.
	localparam int OPW_DEFAULT = 32;

	// Action codes of an input word; the unused code acts as normalize.
	typedef enum logic [2:0] {
		ACT_ADD  = 3'd0,
		ACT_SUB  = 3'd1,
		ACT_MUL  = 3'd2,
		ACT_DIV  = 3'd3,
		ACT_NEG  = 3'd4,
		ACT_CMP  = 3'd5,
		ACT_NORM = 3'd6
	} act_t;

	// Which fraction the shared reduction engine works on.
	typedef enum logic [1:0] {
		SEL_A = 2'd0,
		SEL_B = 2'd1,
		SEL_R = 2'd2
	} sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ld_in;
		logic red_init;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic red_store;
		logic mul;
		logic sum;
		logic out_load;
		sel_t sel;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic gcd_done;
		logic act_red;
	} status_t;

endpackage

`default_nettype wire

/* rtl/rau_in_if.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit input channel
// Valid/ready channel that carries one operand word: action and two fractions.
// ----------------------------------------------------------------------------
`default_nettype none

interface rau_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic signed [31:0] a_num;
	logic signed [31:0] a_den;
	logic signed [31:0] b_num;
	logic [30:0]        b_den;

	modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

`default_nettype wire

/* rtl/rau_out_if.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit output channel
// Valid/ready channel that carries one result word: reduced fraction and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface rau_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] res_num;
	logic [62:0]        res_den;
	logic               greater;
	logic               less;
	logic               equal;

	modport source (output valid, res_num, res_den, greater, less, equal, input ready);
	modport sink (input valid, res_num, res_den, greater, less, equal, output ready);
endinterface

`default_nettype wire

/* rtl/rau_datapath.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Operand registers, the product and sum stage, a binary GCD engine with a
// two-lane restoring divider for reduction, and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_datapath #(
	parameter int OPERAND_WIDTH = rau_pkg::OPW_DEFAULT
) (
	input  wire                 clk,
	input  rau_pkg::cmd_t       cmd,
	output rau_pkg::status_t    st,
	input  wire [2:0]           action,
	input  wire signed [31:0]   a_num,
	input  wire signed [31:0]   a_den,
	input  wire signed [31:0]   b_num,
	input  wire [30:0]          b_den,
	output logic signed [63:0]  res_num,
	output logic [62:0]         res_den,
	output logic                greater,
	output logic                less,
	output logic                equal
);
	import rau_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int W1 = W + 1;
	localparam int WB = W - 1;
	localparam int RW = 2 * W;
	localparam int PW = 2 * W + 2;
	localparam int KW = $clog2(RW) + 1;

	// Captured operand word.
	logic [2:0]          act_q;
	logic signed [W-1:0] an_q, ad_q, bn_q;
	logic [WB-1:0]       bd_q;

	// Reduced operands.
	logic signed [W1-1:0] ra_num_q, rb_num_q;
	logic [W-1:0]         ra_den_q;
	logic [WB-1:0]        rb_den_q;

	// Products and reduction source.
	logic signed [PW-1:0] p1_q, p2_q, p3_q;
	logic signed [RW-1:0] src_num_q, src_den_q;

	// Result before output.
	logic signed [RW-1:0] r_num_q;
	logic [RW-1:0]        r_den_q;
	logic                 gt_q, lt_q, eq_q;

	// Reduction engine.
	logic [RW-1:0] mag_q, d_q, u_q, v_q, g_q, rem1_q, rem2_q;
	logic [KW-1:0] k_q;
	logic          neg_q;

	// Output word.
	logic signed [63:0] res_num_q;
	logic [62:0]        res_den_q;
	logic               greater_q, less_q, equal_q;

	logic signed [RW-1:0] sel_num, sel_den, den0, num1, den1, red_num;
	logic [RW-1:0]        mag_in;
	logic                 neg_in;
	logic signed [W1-1:0] a_d_s, b_d_s, m1_rhs, m3_rhs;
	logic signed [PW-1:0] sum_w, dif_w;
	logic [RW:0]          t1, t2;
	logic                 q1, q2;

	assign st.gcd_done = (u_q == '0);
	assign st.act_red  = (act_q == ACT_ADD) || (act_q == ACT_SUB) ||
		(act_q == ACT_MUL) || (act_q == ACT_DIV);

	// Normalize the selected source: zero denominator, sign move, magnitude.
	always_comb begin
		unique case (cmd.sel)
			SEL_A: begin
				sel_num = RW'(an_q);
				sel_den = RW'(ad_q);
			end
			SEL_B: begin
				sel_num = RW'(bn_q);
				sel_den = $signed(RW'(bd_q));
			end
			default: begin
				sel_num = src_num_q;
				sel_den = src_den_q;
			end
		endcase
		den0   = (sel_den == '0) ? RW'(1) : sel_den;
		num1   = (den0 < 0) ? -sel_num : sel_num;
		den1   = (den0 < 0) ? -den0 : den0;
		neg_in = (num1 < 0);
		mag_in = neg_in ? RW'(-num1) : RW'(num1);
	end

	// Product operands depend on the action.
	assign a_d_s  = $signed({1'b0, ra_den_q});
	assign b_d_s  = $signed({2'b00, rb_den_q});
	assign m1_rhs = (act_q == ACT_MUL) ? rb_num_q : b_d_s;
	assign m3_rhs = (act_q == ACT_DIV) ? rb_num_q : b_d_s;
	assign sum_w  = p1_q + p2_q;
	assign dif_w  = p1_q - p2_q;

	// One restoring division step on both lanes against the common GCD.
	assign t1 = {rem1_q, mag_q[RW-1]};
	assign t2 = {rem2_q, d_q[RW-1]};
	assign q1 = (t1 >= {1'b0, g_q});
	assign q2 = (t2 >= {1'b0, g_q});

	assign red_num = neg_q ? -$signed(mag_q) : $signed(mag_q);

	always_ff @(posedge clk) begin
		// Capture an accepted operand word.
		if (cmd.ld_in) begin
			act_q <= action;
			an_q  <= a_num[W-1:0];
			ad_q  <= a_den[W-1:0];
			bn_q  <= b_num[W-1:0];
			bd_q  <= b_den[WB-1:0];
		end

		// Start a reduction.
		if (cmd.red_init) begin
			mag_q <= mag_in;
			d_q   <= RW'(den1);
			neg_q <= neg_in;
			u_q   <= mag_in;
			v_q   <= RW'(den1);
			k_q   <= '0;
		end

		// One binary GCD step.
		if (cmd.gcd_step) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + KW'(1);
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end

		// Divisor is the GCD with its common powers of two restored.
		if (cmd.div_init) begin
			g_q    <= v_q << k_q;
			rem1_q <= '0;
			rem2_q <= '0;
		end

		// Quotient bits shift into the dividend registers.
		if (cmd.div_step) begin
			rem1_q <= q1 ? RW'(t1 - {1'b0, g_q}) : t1[RW-1:0];
			rem2_q <= q2 ? RW'(t2 - {1'b0, g_q}) : t2[RW-1:0];
			mag_q  <= {mag_q[RW-2:0], q1};
			d_q    <= {d_q[RW-2:0], q2};
		end

		// Store a reduced fraction.
		if (cmd.red_store) begin
			unique case (cmd.sel)
				SEL_A: begin
					ra_num_q <= W1'(red_num);
					ra_den_q <= W'(d_q);
				end
				SEL_B: begin
					rb_num_q <= W1'(red_num);
					rb_den_q <= WB'(d_q);
				end
				default: begin
					r_num_q <= red_num;
					r_den_q <= d_q;
				end
			endcase
		end

		// Products of the reduced operands.
		if (cmd.mul) begin
			p1_q <= ra_num_q * m1_rhs;
			p2_q <= rb_num_q * a_d_s;
			p3_q <= a_d_s * m3_rhs;
		end

		// Combine products, or form the result of actions without reduction.
		if (cmd.sum) begin
			gt_q      <= (act_q == ACT_CMP) && (p1_q > p2_q);
			lt_q      <= (act_q == ACT_CMP) && (p1_q < p2_q);
			eq_q      <= (act_q == ACT_CMP) && (p1_q == p2_q);
			src_den_q <= RW'(p3_q);
			case (act_q) inside
				ACT_ADD: src_num_q <= RW'(sum_w);
				ACT_SUB: src_num_q <= RW'(dif_w);
				ACT_MUL, ACT_DIV: src_num_q <= RW'(p1_q);
				ACT_NEG: begin
					r_num_q <= -(RW'(ra_num_q));
					r_den_q <= RW'(ra_den_q);
				end
				ACT_CMP: begin
					r_num_q <= '0;
					r_den_q <= RW'(1);
				end
				default: begin
					r_num_q <= RW'(ra_num_q);
					r_den_q <= RW'(ra_den_q);
				end
			endcase
		end

		// Output word register.
		if (cmd.out_load) begin
			res_num_q <= 64'(r_num_q);
			res_den_q <= 63'(r_den_q);
			greater_q <= gt_q;
			less_q    <= lt_q;
			equal_q   <= eq_q;
		end
	end

	assign res_num = res_num_q;
	assign res_den = res_den_q;
	assign greater = greater_q;
	assign less    = less_q;
	assign equal   = equal_q;

endmodule

`default_nettype wire

/* rtl/rau_ctrl.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences up to three reductions, the product and sum stage and the output
// word handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_ctrl #(
	parameter int OPERAND_WIDTH = rau_pkg::OPW_DEFAULT
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	input  rau_pkg::status_t    st,
	output rau_pkg::cmd_t       cmd
);
	import rau_pkg::*;

	localparam int RW = 2 * OPERAND_WIDTH;
	localparam int CW = $clog2(RW);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RINIT,
		S_GCD,
		S_DIV,
		S_STORE,
		S_MUL,
		S_SUM,
		S_FIN
	} state_t;

	state_t        state_q;
	sel_t          phase_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          load_out;

	assign load_out = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// Commands decoded from the state.
	always_comb begin
		cmd           = '0;
		cmd.sel       = phase_q;
		cmd.ld_in     = (state_q == S_IDLE) && in_valid;
		cmd.red_init  = (state_q == S_RINIT);
		cmd.gcd_step  = (state_q == S_GCD) && !st.gcd_done;
		cmd.div_init  = (state_q == S_GCD) && st.gcd_done;
		cmd.div_step  = (state_q == S_DIV);
		cmd.red_store = (state_q == S_STORE);
		cmd.mul       = (state_q == S_MUL);
		cmd.sum       = (state_q == S_SUM);
		cmd.out_load  = load_out;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// State, phase, step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= SEL_A;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result takes the register as the old one leaves.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						phase_q <= SEL_A;
						state_q <= S_RINIT;
					end
				end
				S_RINIT: state_q <= S_GCD;
				S_GCD: begin
					if (st.gcd_done) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(RW - 1)) begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					unique case (phase_q)
						SEL_A: begin
							phase_q <= SEL_B;
							state_q <= S_RINIT;
						end
						SEL_B: state_q <= S_MUL;
						default: state_q <= S_FIN;
					endcase
				end
				S_MUL: state_q <= S_SUM;
				S_SUM: begin
					if (st.act_red) begin
						phase_q <= SEL_R;
						state_q <= S_RINIT;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/rational_arith_unit.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides, negates, compares or normalizes
// fractions and returns the result reduced by its greatest common divisor.
// ----------------------------------------------------------------------------
// Usage: an operand word enters on in_ch (valid/ready) and exactly one result
// word leaves on out_ch. The unit works on one word at a time; in_ch.ready is
// high only while the controller is idle.
// Sequence: each reduction has a setup step, binary GCD steps until the GCD
// is found (data dependent), a step that forms the divisor, a divider step
// for each of the 2*OPERAND_WIDTH quotient bits and a store step. Both operands
// are reduced, and add, subtract, multiply and divide reduce the result a
// third time; the products, the sum and the output load follow. The unit is
// ready for the next word as soon as its result is valid; negate, compare and
// normalize skip the third reduction. The rate is set by the single shared
// GCD engine and its 1-bit-per-cycle divider.
// Reset clears the controller and the output valid; no word is in flight.
// A stalled receiver holds the result in the output register; the next word
// is taken and worked on meanwhile and waits at the end until the register
// is free.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arith_unit #(
	parameter int OPERAND_WIDTH = rau_pkg::OPW_DEFAULT
) (
	input wire       clk,
	input wire       arst_n,
	rau_in_if.sink   in_ch,
	rau_out_if.source out_ch
);
	import rau_pkg::*;

	cmd_t    cmd;
	status_t st;

	rau_ctrl #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	rau_datapath #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_datapath (
		.clk    (clk),
		.cmd    (cmd),
		.st     (st),
		.action (in_ch.action),
		.a_num  (in_ch.a_num),
		.a_den  (in_ch.a_den),
		.b_num  (in_ch.b_num),
		.b_den  (in_ch.b_den),
		.res_num(out_ch.res_num),
		.res_den(out_ch.res_den),
		.greater(out_ch.greater),
		.less   (out_ch.less),
		.equal  (out_ch.equal)
	);

	// A reduced denominator is never zero.
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.res_den != '0))
		else $error("result denominator is zero");

	// At most one compare flag is set.
	a_flags_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> $onehot0({out_ch.greater, out_ch.less, out_ch.equal}))
		else $error("more than one compare flag set");

	// After a word is taken the unit is busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input ready right after an accepted word");

endmodule

`default_nettype wire

/* sim/rational_arith_unit_tb.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Sends operand words, mostly with random gaps, predicts each reduced result with an
// independent fraction model and checks every result word field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arith_unit_tb;
	import rau_pkg::*;

	typedef struct {
		logic signed [63:0] num;
		logic [62:0]        den;
		logic               gt;
		logic               lt;
		logic               eq;
	} frac_res_t;

	logic clk;
	logic arst_n;
	int   errors;
	int   quiet_cycles;
	bit   gaps_on;
	frac_res_t expected_q[$];

	rau_in_if  in_ch();
	rau_out_if out_ch();

	rational_arith_unit uut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	// Clock with a period of 10.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Euclidean reduction of a fraction with sign moved to the numerator.
	function automatic void reduce_frac(input longint n, input longint d,
		output longint rn, output longint rd);
		longint unsigned mag;
		longint unsigned dm;
		longint unsigned x;
		longint unsigned y;
		longint unsigned t;
		bit neg;
		if (d == 0) d = 1;
		if (d < 0) begin
			d = -d;
			n = -n;
		end
		neg = n < 0;
		mag = neg ? -n : n;
		dm = d;
		x = (mag > dm) ? mag : dm;
		y = (mag > dm) ? dm : mag;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		mag = mag / x;
		dm = dm / x;
		rn = neg ? -longint'(mag) : longint'(mag);
		rd = dm;
	endfunction

	// Predicts the result word of one operand word.
	function automatic frac_res_t predict_frac(input logic [2:0] act,
		input logic signed [31:0] an, input logic signed [31:0] ad,
		input logic signed [31:0] bn, input logic [30:0] bd);
		frac_res_t r;
		longint xn, xd, yn, yd, rn, rd, l, rr;
		reduce_frac(longint'(an), longint'(ad), xn, xd);
		reduce_frac(longint'(bn), longint'(bd), yn, yd);
		r.gt = 0;
		r.lt = 0;
		r.eq = 0;
		case (act)
			ACT_ADD: reduce_frac(xn * yd + yn * xd, xd * yd, rn, rd);
			ACT_SUB: reduce_frac(xn * yd - yn * xd, xd * yd, rn, rd);
			ACT_MUL: reduce_frac(xn * yn, xd * yd, rn, rd);
			ACT_DIV: reduce_frac(xn * yd, xd * yn, rn, rd);
			ACT_NEG: begin
				rn = -xn;
				rd = xd;
			end
			ACT_CMP: begin
				l = xn * yd;
				rr = yn * xd;
				r.gt = l > rr;
				r.lt = l < rr;
				r.eq = l == rr;
				rn = 0;
				rd = 1;
			end
			default: begin
				rn = xn;
				rd = xd;
			end
		endcase
		r.num = rn;
		r.den = rd[62:0];
		return r;
	endfunction

	// Sends one word with an optional random gap in front of it.
	task automatic send_word(input logic [2:0] act, input logic signed [31:0] an,
		input logic signed [31:0] ad, input logic signed [31:0] bn,
		input logic [30:0] bd);
		if (gaps_on && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 18)) @(negedge clk);
		in_ch.valid  = 1'b1;
		in_ch.action = act;
		in_ch.a_num  = an;
		in_ch.a_den  = ad;
		in_ch.b_num  = bn;
		in_ch.b_den  = bd;
		expected_q.push_back(predict_frac(act, an, ad, bn, bd));
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	function automatic logic signed [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 20) - 10;
			1: return 32'sh8000_0000;
			2: return 32'sh7fff_ffff;
			3: return $urandom_range(0, 2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] rand_bden();
		case ($urandom_range(0, 4))
			0: return 31'($urandom_range(0, 12));
			1: return 31'h7fff_ffff;
			default: return 31'($urandom);
		endcase
	endfunction

	// Receiver side: the result check on each accepted result word.
	always @(posedge clk) begin
		frac_res_t e;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (out_ch.res_num !== e.num) begin
					$error("res_num expected %0d got %0d", e.num, out_ch.res_num);
					errors++;
				end
				if (out_ch.res_den !== e.den) begin
					$error("res_den expected %0d got %0d", e.den, out_ch.res_den);
					errors++;
				end
				if (out_ch.greater !== e.gt) begin
					$error("greater expected %0b got %0b", e.gt, out_ch.greater);
					errors++;
				end
				if (out_ch.less !== e.lt) begin
					$error("less expected %0b got %0b", e.lt, out_ch.less);
					errors++;
				end
				if (out_ch.equal !== e.eq) begin
					$error("equal expected %0b got %0b", e.eq, out_ch.equal);
					errors++;
				end
			end
		end
	end

	// Stall bursts on the result side change at the falling edge.
	initial begin
		out_ch.ready = 1'b1;
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 15) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no accepted word on either side.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic wait_drained();
		while (expected_q.size() != 0) @(negedge clk);
	endtask

	// Field extremes and each named special case.
	task automatic test_directed();
		send_word(ACT_NORM, 32'sh8000_0000, 32'sh7fff_ffff, 0, 1);
		send_word(ACT_NORM, 6, 0, 0, 1);
		send_word(ACT_NORM, 6, -4, 0, 1);
		send_word(3'd7, -12, -18, 0, 1);
		send_word(ACT_NORM, 0, -5, 0, 1);
		send_word(ACT_ADD, 1, 2, 1, 3);
		send_word(ACT_ADD, 32'sh8000_0000, 1, 32'sh8000_0000, 0);
		send_word(ACT_SUB, 1, 3, 1, 3);
		send_word(ACT_SUB, 32'sh7fff_ffff, -32'sh7fff_ffff, 32'sh8000_0000,
			31'h7fff_ffff);
		send_word(ACT_MUL, 32'sh8000_0000, 1, 32'sh8000_0000, 1);
		send_word(ACT_MUL, 2, 3, -3, 2);
		send_word(ACT_DIV, 3, 4, 0, 5);
		send_word(ACT_DIV, 3, 4, -6, 7);
		send_word(ACT_DIV, 32'sh8000_0000, 3, 32'sh7fff_ffff, 31'h7fff_fffe);
		send_word(ACT_NEG, 32'sh8000_0000, -1, 0, 1);
		send_word(ACT_NEG, 0, 7, 0, 1);
		send_word(ACT_CMP, 1, 2, 2, 4);
		send_word(ACT_CMP, 1, 2, 1, 3);
		send_word(ACT_CMP, -1, 2, 1, 3);
		send_word(ACT_CMP, 32'sh7fff_ffff, 1, 32'sh8000_0000, 31'h7fff_ffff);
		send_word(ACT_ADD, 32'sh5555_5555, 32'sh2aaa_aaaa, 32'sh2aaa_aaaa,
			31'h5555_5555);
	endtask

	// Random words of every action code, the unused one included.
	task automatic test_random(input int count);
		for (int i = 0; i < count; i++)
			send_word(3'($urandom_range(0, 7)), rand_operand(), rand_operand(),
				rand_operand(), rand_bden());
	endtask

	initial begin
		errors = 0;
		quiet_cycles = 0;
		gaps_on = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_ADD;
		in_ch.a_num = 0;
		in_ch.a_den = 1;
		in_ch.b_num = 0;
		in_ch.b_den = 1;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		gaps_on = 1'b1;
		test_directed();
		test_random(500);
		wait_drained();
		test_random(550);
		gaps_on = 1'b0;
		test_random(150);
		wait_drained();
		repeat (1000) @(negedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
rtl/rau_pkg.sv
rtl/rau_in_if.sv
rtl/rau_out_if.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arith_unit.sv
sim/rational_arith_unit_tb.sv
